// ===== src/rfd_pkg.sv =====
// Shared types and constants for the RGB frame decimator.
// No dependencies; imported by rfd_rem and rgb_frame_decimator.
package rfd_pkg;

    localparam int CH_W       = 8;
    localparam int PIX_W      = 3 * CH_W;
    localparam int PSUM_W     = CH_W + 1;
    localparam int LINE_W     = 3 * PSUM_W;
    localparam int ROW_W      = 12;
    localparam int FACTOR_W   = 5;
    localparam int CFG_W      = 13;
    localparam int IDX_W      = 2;

    localparam int RST_FACTOR = 2;
    localparam int RST_WIDTH  = 640;
    localparam int RST_HEIGHT = 480;
    localparam int HEIGHT_MAX = 4096;

    typedef enum logic [IDX_W-1:0] {
        REG_MODE   = 2'd0,
        REG_FACTOR = 2'd1,
        REG_WIDTH  = 2'd2,
        REG_HEIGHT = 2'd3
    } rfd_reg_t;

    typedef struct packed {
        logic busy;
        logic done;
    } rfd_rem_stat_t;

endpackage

// ===== src/rgb_frame_decimator.sv =====
// Top level of the RGB frame decimator: subsampling or 2x2 box averaging of a pixel stream.
// Depends on rfd_pkg, rfd_ram (line store of pair sums) and rfd_rem (factor remainders).
//
//   channel | dir | handshake        | payload
//   s_      | in  | s_tvalid/tready  | s_tdata: chan0, chan1, chan2
//   m_      | out | m_tvalid/tready  | m_tdata: out0, out1, out2; m_tlast: frame_end
//   cfg_    | in  | cfg_we           | cfg_index, cfg_data
//
// One pixel per cycle is accepted while the remainder unit is idle and stage 1 can advance;
// a result passes the middle stage and the line store read, then the output register, to m_.
// Each write to the factor register blocks input while the bit-serial remainder unit
// rebuilds the column and row phases.
// Reset is asynchronous and clears counters, phases and valid flags; the line store is not
// cleared. m_tready stalls the output register and, through it, the single middle stage.
module rgb_frame_decimator
    import rfd_pkg::*;
#(
    parameter int MAX_WIDTH = 4096
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [23:0]      s_tdata,   // [7:0] chan0, [15:8] chan1, [23:16] chan2
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [23:0]      m_tdata,   // [7:0] out0, [15:8] out1, [23:16] out2
    output logic             m_tlast,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int CW         = $clog2(MAX_WIDTH);
    localparam int WW         = $clog2(MAX_WIDTH + 1);
    localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int AW         = CW - 1;
    localparam int CMPW       = (WW > CFG_W) ? WW : CFG_W;
    localparam int SW         = WW + 6;
    localparam logic [WW-1:0] RST_W_EFF =
        WW'((MAX_WIDTH < RST_WIDTH) ? MAX_WIDTH : RST_WIDTH);

    // configuration, kept in effective (saturated) form
    logic                mode_reg;
    logic [FACTOR_W-1:0] f_reg;
    logic [WW-1:0]       w_reg;
    logic [CFG_W-1:0]    h_reg;

    logic [CW-1:0]       col_reg, col_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [FACTOR_W-1:0] xph_reg, xph_next;
    logic [FACTOR_W-1:0] yph_reg, yph_next;
    logic [PIX_W-1:0]    left_reg, left_next;

    logic                s1_valid_reg, s1_valid_next;
    logic                s1_avg_reg, s1_avg_next;
    logic                s1_last_reg, s1_last_next;
    logic [PIX_W-1:0]    s1_pix_reg, s1_pix_next;
    logic [PIX_W-1:0]    s1_left_reg, s1_left_next;

    logic                out_valid_reg, out_valid_next;
    logic                out_last_reg, out_last_next;
    logic [PIX_W-1:0]    out_data_reg, out_data_next;

    logic                accept;
    logic                s1_adv;
    logic                in_frame;
    logic [WW-1:0]       col_inc;
    logic [CFG_W-1:0]    row_inc;
    logic [FACTOR_W:0]   xph_inc;
    logic [FACTOR_W:0]   yph_inc;
    logic                ram_we;
    logic                ram_re;
    logic [LINE_W-1:0]   ram_wdata;
    logic [LINE_W-1:0]   ram_rdata;
    logic [AW-1:0]       line_addr;
    logic [PIX_W-1:0]    avg_pix;

    logic                rem_start;
    logic [FACTOR_W-1:0] f_wr;
    logic [CMPW-1:0]     w_in;
    logic [CMPW-1:0]     w_sat;
    logic [CFG_W-1:0]    h_sat;
    rfd_rem_stat_t       rem_stat;
    logic [FACTOR_W-1:0] col_rem;
    logic [FACTOR_W-1:0] row_rem;

    // ---------------- configuration ----------------
    always_comb
    begin
        f_wr = (cfg_data[FACTOR_W-1:0] == '0) ? FACTOR_W'(1) : cfg_data[FACTOR_W-1:0];
        w_in = CMPW'(cfg_data);
        if (w_in < CMPW'(2))
        begin
            w_sat = CMPW'(2);
        end
        else if (w_in > CMPW'(MAX_WIDTH))
        begin
            w_sat = CMPW'(MAX_WIDTH);
        end
        else
        begin
            w_sat = w_in;
        end
        if (cfg_data < CFG_W'(2))
        begin
            h_sat = CFG_W'(2);
        end
        else if (cfg_data > CFG_W'(HEIGHT_MAX))
        begin
            h_sat = CFG_W'(HEIGHT_MAX);
        end
        else
        begin
            h_sat = cfg_data;
        end
        rem_start = cfg_we && (rfd_reg_t'(cfg_index) == REG_FACTOR);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
            f_reg    <= FACTOR_W'(RST_FACTOR);
            w_reg    <= RST_W_EFF;
            h_reg    <= CFG_W'(RST_HEIGHT);
        end
        else if (cfg_we)
        begin
            case (rfd_reg_t'(cfg_index))
                REG_MODE:   mode_reg <= cfg_data[0];
                REG_FACTOR: f_reg    <= f_wr;
                REG_WIDTH:  w_reg    <= w_sat[WW-1:0];
                REG_HEIGHT: h_reg    <= h_sat;
                default:    mode_reg <= mode_reg;
            endcase
        end
    end

    // phases are rebuilt as col % factor and row % factor after a factor change
    rfd_rem #(
        .COL_W (CW)
    ) u_rem (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (rem_start),
        .divisor (f_wr),
        .col     (col_reg),
        .row     (row_reg),
        .stat    (rem_stat),
        .col_rem (col_rem),
        .row_rem (row_rem)
    );

    // ---------------- handshake ----------------
    assign s1_adv   = !out_valid_reg || m_tready;
    assign s_tready = !rem_stat.busy && !rem_stat.done && (!s1_valid_reg || s1_adv);
    assign accept   = s_tvalid && s_tready;

    // ---------------- position, line store access, stage 1 ----------------
    assign line_addr = col_reg[CW-1:1];

    always_comb
    begin
        col_inc  = WW'(col_reg) + WW'(1);
        row_inc  = CFG_W'(row_reg) + CFG_W'(1);
        xph_inc  = (FACTOR_W + 1)'(xph_reg) + (FACTOR_W + 1)'(1);
        yph_inc  = (FACTOR_W + 1)'(yph_reg) + (FACTOR_W + 1)'(1);
        in_frame = (WW'(col_reg) < w_reg) && (CFG_W'(row_reg) < h_reg);

        col_next = col_reg;
        row_next = row_reg;
        xph_next = xph_reg;
        yph_next = yph_reg;
        left_next = left_reg;

        s1_valid_next = s1_valid_reg;
        s1_avg_next   = s1_avg_reg;
        s1_last_next  = s1_last_reg;
        s1_pix_next   = s1_pix_reg;
        s1_left_next  = s1_left_reg;

        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_wdata = '0;
        for (int k = 0; k < 3; k++)
        begin
            ram_wdata[k*PSUM_W +: PSUM_W] = PSUM_W'(left_reg[k*CH_W +: CH_W])
                                          + PSUM_W'(s_tdata[k*CH_W +: CH_W]);
        end

        if (rem_stat.done)
        begin
            xph_next = col_rem;
            yph_next = row_rem;
        end

        if (!accept && s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        if (accept)
        begin
            s1_valid_next = 1'b0;
            s1_pix_next   = s_tdata;
            s1_left_next  = left_reg;
            if (!mode_reg)
            begin
                s1_avg_next  = 1'b0;
                s1_last_next = (SW'(col_reg) + SW'(f_reg) >= SW'(w_reg))
                            && (CFG_W'(row_reg) + CFG_W'(f_reg) >= h_reg);
                if (in_frame && xph_reg == '0 && yph_reg == '0)
                begin
                    s1_valid_next = 1'b1;
                end
            end
            else
            begin
                s1_avg_next  = 1'b1;
                s1_last_next = (col_inc == {w_reg[WW-1:1], 1'b0})
                            && (row_inc == {h_reg[CFG_W-1:1], 1'b0});
                if (in_frame)
                begin
                    if (!col_reg[0])
                    begin
                        left_next = s_tdata;
                    end
                    else if (!row_reg[0])
                    begin
                        ram_we = 1'b1;
                    end
                    else
                    begin
                        // entry was written a full row earlier: no overlap to forward
                        ram_re        = 1'b1;
                        s1_valid_next = 1'b1;
                    end
                end
            end

            // advance the raster position and the factor phases
            if (col_inc >= w_reg)
            begin
                col_next = '0;
                xph_next = '0;
                if (row_inc >= h_reg)
                begin
                    row_next = '0;
                    yph_next = '0;
                end
                else
                begin
                    row_next = row_inc[ROW_W-1:0];
                    yph_next = (yph_inc >= (FACTOR_W + 1)'(f_reg)) ? '0
                                                                   : yph_inc[FACTOR_W-1:0];
                end
            end
            else
            begin
                col_next = col_inc[CW-1:0];
                xph_next = (xph_inc >= (FACTOR_W + 1)'(f_reg)) ? '0 : xph_inc[FACTOR_W-1:0];
            end
        end
    end

    rfd_ram #(
        .DATA_W (LINE_W),
        .DEPTH  (LINE_DEPTH)
    ) u_line (
        .clk   (clk),
        .we    (ram_we),
        .waddr (line_addr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (line_addr),
        .rdata (ram_rdata)
    );

    // ---------------- stage 2: average and output register ----------------
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            avg_pix[k*CH_W +: CH_W] = 8'((10'(ram_rdata[k*PSUM_W +: PSUM_W])
                                        + 10'(s1_left_reg[k*CH_W +: CH_W])
                                        + 10'(s1_pix_reg[k*CH_W +: CH_W])) >> 2);
        end
        out_valid_next = out_valid_reg;
        out_last_next  = out_last_reg;
        out_data_next  = out_data_reg;
        if (s1_adv)
        begin
            out_valid_next = s1_valid_reg;
            if (s1_valid_reg)
            begin
                out_last_next = s1_last_reg;
                out_data_next = s1_avg_reg ? avg_pix : s1_pix_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            xph_reg       <= '0;
            yph_reg       <= '0;
            left_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            xph_reg       <= xph_next;
            yph_reg       <= yph_next;
            left_reg      <= left_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_avg_reg   <= s1_avg_next;
        s1_last_reg  <= s1_last_next;
        s1_pix_reg   <= s1_pix_next;
        s1_left_reg  <= s1_left_next;
        out_last_reg <= out_last_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

`ifndef SYNTH
    a_no_transfer_during_rem: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !rem_stat.busy && !rem_stat.done)
        else $error("input transfer while phases are being rebuilt");

    a_phase_below_factor: assert property (@(posedge clk) disable iff (!rst_n)
        !rem_stat.busy && !rem_stat.done |-> xph_reg < f_reg && yph_reg < f_reg)
        else $error("factor phase out of range");

    a_line_one_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("line store read and write in the same cycle");

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_adv |=> s1_valid_reg && $stable(ram_rdata))
        else $error("stalled stage lost its line store word");

    a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        WW'(col_reg) < WW'(MAX_WIDTH))
        else $error("column counter beyond line length");
`endif

endmodule

// ===== src/rfd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module rfd_ram #(
    parameter int DATA_W = 27,
    parameter int DEPTH  = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // hold the last read word while no new read is issued
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/rfd_rem.sv =====
// Bit-serial remainder unit: column and row counters modulo the subsampling factor.
// Depends on rfd_pkg.
module rfd_rem
    import rfd_pkg::*;
#(
    parameter int COL_W = 12
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [FACTOR_W-1:0] divisor,
    input  logic [COL_W-1:0]    col,
    input  logic [ROW_W-1:0]    row,
    output rfd_rem_stat_t       stat,
    output logic [FACTOR_W-1:0] col_rem,
    output logic [FACTOR_W-1:0] row_rem
);

    localparam int RN    = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int CNT_W = $clog2(RN + 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [FACTOR_W-1:0] div_reg, div_next;
    logic [RN-1:0]       colq_reg, colq_next;
    logic [RN-1:0]       rowq_reg, rowq_next;
    logic [FACTOR_W-1:0] crem_reg, crem_next;
    logic [FACTOR_W-1:0] rrem_reg, rrem_next;

    // one restoring step: bring in the next dividend bit, subtract if it fits
    function automatic logic [FACTOR_W-1:0] rem_step(
        input logic [FACTOR_W-1:0] rem,
        input logic                bit_in,
        input logic [FACTOR_W-1:0] dv
    );
        logic [FACTOR_W:0] trial;
        logic [FACTOR_W:0] diff;
        trial = {rem, bit_in};
        diff  = trial - {1'b0, dv};
        if (trial >= {1'b0, dv})
        begin
            rem_step = diff[FACTOR_W-1:0];
        end
        else
        begin
            rem_step = trial[FACTOR_W-1:0];
        end
    endfunction

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        div_next  = div_reg;
        colq_next = colq_reg;
        rowq_next = rowq_reg;
        crem_next = crem_reg;
        rrem_next = rrem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            div_next  = divisor;
            colq_next = RN'(col);
            rowq_next = RN'(row);
            crem_next = '0;
            rrem_next = '0;
        end
        else if (busy_reg)
        begin
            crem_next = rem_step(crem_reg, colq_reg[RN-1], div_reg);
            rrem_next = rem_step(rrem_reg, rowq_reg[RN-1], div_reg);
            colq_next = {colq_reg[RN-2:0], 1'b0};
            rowq_next = {rowq_reg[RN-2:0], 1'b0};
            cnt_next  = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(RN - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg  <= div_next;
        colq_reg <= colq_next;
        rowq_reg <= rowq_next;
        crem_reg <= crem_next;
        rrem_reg <= rrem_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign col_rem   = crem_reg;
    assign row_rem   = rrem_reg;

endmodule
